/* hdl/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure/temperature compensation block:
// calibration word layout, register indexes, datapath widths and shifts.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

   // Field widths
   localparam int RAW_W  = 24;   // raw conversions
   localparam int CAL_W  = 16;   // calibration words
   localparam int CIDX_W = 3;    // register index
   localparam int OUT_W  = 32;   // results

   // Datapath widths
   localparam int DT_W    = 25;  // dT, signed
   localparam int MT_W    = 42;  // dT * calibration word, signed
   localparam int SQD_W   = 50;  // dT * dT, signed (never negative)
   localparam int Q_W     = 19;  // dT * C6 / 2^23, signed
   localparam int T_W     = 20;  // first-order temperature, signed
   localparam int T2_W    = 28;  // second-order temperature term, unsigned
   localparam int SQ_W    = 35;  // (T - 2000)^2, unsigned
   localparam int OFF_W   = 38;  // offset and sensitivity, signed
   localparam int OFF2_W  = 36;  // second-order offset term, unsigned
   localparam int SENS2_W = 34;  // second-order sensitivity term, unsigned
   localparam int SPLIT   = 19;  // low slice of sensitivity for the split multiply
   localparam int PLO_W   = RAW_W + SPLIT;              // unsigned low partial
   localparam int PHI_W   = RAW_W + 1 + OFF_W - SPLIT;  // signed high partial
   localparam int PROD_W  = 63;  // D1 * SENS, signed
   localparam int ACC_W   = 44;  // D1 * SENS / 2^21 - OFF, signed

   // Scale shifts
   localparam int C5_SH   = 8;
   localparam int C2_SH   = 16;
   localparam int C1_SH   = 14;
   localparam int OFF_SH  = 7;
   localparam int SENS_SH = 8;
   localparam int T_SH    = 23;
   localparam int T2_SH   = 23;
   localparam int P1_SH   = 21;
   localparam int P2_SH   = 13;

   localparam int TEMP_BASE = 2000;   // 20.00 degC

   // Pipeline depth from accepted transaction to result register
   localparam int STAGES = 10;

   typedef enum logic [CIDX_W-1:0] {
      CSR_SENS_BASE         = 3'd0,
      CSR_OFFSET_BASE       = 3'd1,
      CSR_SENS_TEMP_COEFF   = 3'd2,
      CSR_OFFSET_TEMP_COEFF = 3'd3,
      CSR_REF_TEMPERATURE   = 3'd4,
      CSR_TEMP_SLOPE        = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CAL_W-1:0] sens_base;
      logic [CAL_W-1:0] offset_base;
      logic [CAL_W-1:0] sens_temp_coeff;
      logic [CAL_W-1:0] offset_temp_coeff;
      logic [CAL_W-1:0] ref_temperature;
      logic [CAL_W-1:0] temp_slope;
   } cal_type;

   typedef struct packed {
      logic [STAGES-1:0] stage_valid;
   } status_type;

endpackage

`default_nettype wire

/* hdl/ptc_core.sv */
// ----------------------------------------------------------------------------
// ptc_core
// Ten-stage compensation pipeline. Each stage holds a valid bit and loads
// when it is empty or when the stage after it moves, so bubbles collapse
// and a stalled result holds without losing or repeating a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ptc_pkg::cal_type              cal,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ptc_pkg::RAW_W-1:0]     req_raw_pressure,
   input  wire logic [ptc_pkg::RAW_W-1:0]     req_raw_temperature,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [ptc_pkg::OUT_W-1:0]   rsp_temperature_centi_c,
   output logic signed [ptc_pkg::OUT_W-1:0]   rsp_pressure_centi_mbar,
   output ptc_pkg::status_type                status
);
   import ptc_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] load;

   // ---------------- flow control ----------------
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};
   assign req_stall = !load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_in & load) | (valid_ff & ~load);
      end
   end

   // ---------------- stage 1: dT ----------------
   logic [DT_W:0]            dt_full;
   logic signed [DT_W-1:0]   s1_dt_ff;
   logic [RAW_W-1:0]         s1_d1_ff;

   assign dt_full = {2'b00, req_raw_temperature}
                  - ((DT_W+1)'(cal.ref_temperature) << C5_SH);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_dt_ff <= $signed(dt_full[DT_W-1:0]);
         s1_d1_ff <= req_raw_pressure;
      end
   end

   // ---------------- stage 2: dT products ----------------
   logic signed [MT_W-1:0]  pc4_in, pc3_in, pc6_in;
   logic signed [SQD_W-1:0] pdt_in;
   logic signed [MT_W-1:0]  s2_pc4_ff, s2_pc3_ff, s2_pc6_ff;
   logic signed [SQD_W-1:0] s2_pdt_ff;
   logic [RAW_W-1:0]        s2_d1_ff;

   assign pc4_in = MT_W'(s1_dt_ff) * MT_W'($signed({1'b0, cal.offset_temp_coeff}));
   assign pc3_in = MT_W'(s1_dt_ff) * MT_W'($signed({1'b0, cal.sens_temp_coeff}));
   assign pc6_in = MT_W'(s1_dt_ff) * MT_W'($signed({1'b0, cal.temp_slope}));
   assign pdt_in = SQD_W'(s1_dt_ff) * SQD_W'(s1_dt_ff);

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_pc4_ff <= pc4_in;
         s2_pc3_ff <= pc3_in;
         s2_pc6_ff <= pc6_in;
         s2_pdt_ff <= pdt_in;
         s2_d1_ff  <= s1_d1_ff;
      end
   end

   // ---------------- stage 3: OFF, SENS, T, T2 ----------------
   // Signed shifts round toward zero: bias negative values before shifting.
   logic signed [MT_W-1:0]  pc4_b, pc3_b, pc6_b;
   logic signed [MT_W-1:0]  off_q, sens_q, q_full;
   logic [SQD_W:0]          tri_dt;
   logic signed [OFF_W-1:0] off_in, sens_in;
   logic signed [Q_W-1:0]   q_in;
   logic signed [T_W-1:0]   t_in;
   logic [T2_W-1:0]         t2_in;

   logic signed [OFF_W-1:0] s3_off_ff, s3_sens_ff;
   logic signed [Q_W-1:0]   s3_q_ff;
   logic signed [T_W-1:0]   s3_t_ff;
   logic [T2_W-1:0]         s3_t2_ff;
   logic                    s3_neg_ff;
   logic [RAW_W-1:0]        s3_d1_ff;

   assign pc4_b  = s2_pc4_ff + $signed(MT_W'({OFF_SH{s2_pc4_ff[MT_W-1]}}));
   assign pc3_b  = s2_pc3_ff + $signed(MT_W'({SENS_SH{s2_pc3_ff[MT_W-1]}}));
   assign pc6_b  = s2_pc6_ff + $signed(MT_W'({T_SH{s2_pc6_ff[MT_W-1]}}));
   assign off_q  = pc4_b >>> OFF_SH;
   assign sens_q = pc3_b >>> SENS_SH;
   assign q_full = pc6_b >>> T_SH;

   assign off_in  = $signed(OFF_W'(cal.offset_base) << C2_SH)
                  + $signed(off_q[OFF_W-1:0]);
   assign sens_in = $signed(OFF_W'(cal.sens_base) << C1_SH)
                  + $signed(sens_q[OFF_W-1:0]);
   assign q_in    = $signed(q_full[Q_W-1:0]);
   assign t_in    = $signed(T_W'(TEMP_BASE)) + T_W'(q_in);

   // 3 * dT^2, dT^2 is never negative
   assign tri_dt = {1'b0, s2_pdt_ff} + {s2_pdt_ff, 1'b0};
   assign t2_in  = tri_dt[T2_SH +: T2_W];

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s3_off_ff  <= off_in;
         s3_sens_ff <= sens_in;
         s3_q_ff    <= q_in;
         s3_t_ff    <= t_in;
         s3_t2_ff   <= t2_in;
         s3_neg_ff  <= q_in[Q_W-1];   // T below 20.00 degC
         s3_d1_ff   <= s2_d1_ff;
      end
   end

   // ---------------- stage 4: (T - 2000)^2 ----------------
   logic signed [2*Q_W-1:0] sq_full;
   logic [SQ_W-1:0]         s4_sq_ff;
   logic signed [OFF_W-1:0] s4_off_ff, s4_sens_ff;
   logic signed [T_W-1:0]   s4_t_ff;
   logic [T2_W-1:0]         s4_t2_ff;
   logic                    s4_neg_ff;
   logic [RAW_W-1:0]        s4_d1_ff;

   assign sq_full = (2*Q_W)'(s3_q_ff) * (2*Q_W)'(s3_q_ff);

   always_ff @(posedge clock) begin
      if (load[3]) begin
         s4_sq_ff   <= sq_full[SQ_W-1:0];
         s4_off_ff  <= s3_off_ff;
         s4_sens_ff <= s3_sens_ff;
         s4_t_ff    <= s3_t_ff;
         s4_t2_ff   <= s3_t2_ff;
         s4_neg_ff  <= s3_neg_ff;
         s4_d1_ff   <= s3_d1_ff;
      end
   end

   // ---------------- stage 5: second-order terms ----------------
   logic [SQ_W+1:0]         off2_full, sens2_full;
   logic [OFF2_W-1:0]       off2_in;
   logic [SENS2_W-1:0]      sens2_in;
   logic [T2_W-1:0]         t2_sel;

   logic [OFF2_W-1:0]       s5_off2_ff;
   logic [SENS2_W-1:0]      s5_sens2_ff;
   logic signed [OFF_W-1:0] s5_off_ff, s5_sens_ff;
   logic signed [T_W-1:0]   s5_t_ff;
   logic [T2_W-1:0]         s5_t2_ff;
   logic [RAW_W-1:0]        s5_d1_ff;

   assign off2_full  = {2'b00, s4_sq_ff} + {1'b0, s4_sq_ff, 1'b0};
   assign sens2_full = {2'b00, s4_sq_ff} + {s4_sq_ff, 2'b00};

   // Drop all corrections at or above 20.00 degC
   assign off2_in  = s4_neg_ff ? off2_full[SQ_W+1:1]  : '0;
   assign sens2_in = s4_neg_ff ? sens2_full[SQ_W+1:3] : '0;
   assign t2_sel   = s4_neg_ff ? s4_t2_ff             : '0;

   always_ff @(posedge clock) begin
      if (load[4]) begin
         s5_off2_ff  <= off2_in;
         s5_sens2_ff <= sens2_in;
         s5_off_ff   <= s4_off_ff;
         s5_sens_ff  <= s4_sens_ff;
         s5_t_ff     <= s4_t_ff;
         s5_t2_ff    <= t2_sel;
         s5_d1_ff    <= s4_d1_ff;
      end
   end

   // ---------------- stage 6: corrected OFF, SENS, temperature ----------------
   logic signed [OFF_W-1:0] offc_in, sensc_in;
   logic [OUT_W-1:0]        temp_in;

   logic signed [OFF_W-1:0] s6_offc_ff, s6_sensc_ff;
   logic [OUT_W-1:0]        s6_temp_ff;
   logic [RAW_W-1:0]        s6_d1_ff;

   assign offc_in  = s5_off_ff  - $signed(OFF_W'(s5_off2_ff));
   assign sensc_in = s5_sens_ff - $signed(OFF_W'(s5_sens2_ff));
   assign temp_in  = OUT_W'(s5_t_ff) - OUT_W'(s5_t2_ff);

   always_ff @(posedge clock) begin
      if (load[5]) begin
         s6_offc_ff  <= offc_in;
         s6_sensc_ff <= sensc_in;
         s6_temp_ff  <= temp_in;
         s6_d1_ff    <= s5_d1_ff;
      end
   end

   // ---------------- stage 7: D1 * SENS partial products ----------------
   logic [PLO_W-1:0]        plo_in;
   logic signed [PHI_W-1:0] phi_in;

   logic [PLO_W-1:0]        s7_plo_ff;
   logic signed [PHI_W-1:0] s7_phi_ff;
   logic signed [OFF_W-1:0] s7_offc_ff;
   logic [OUT_W-1:0]        s7_temp_ff;

   assign plo_in = PLO_W'(s6_d1_ff) * PLO_W'(s6_sensc_ff[SPLIT-1:0]);
   assign phi_in = PHI_W'($signed({1'b0, s6_d1_ff}))
                 * PHI_W'($signed(s6_sensc_ff[OFF_W-1:SPLIT]));

   always_ff @(posedge clock) begin
      if (load[6]) begin
         s7_plo_ff  <= plo_in;
         s7_phi_ff  <= phi_in;
         s7_offc_ff <= s6_offc_ff;
         s7_temp_ff <= s6_temp_ff;
      end
   end

   // ---------------- stage 8: combine partials ----------------
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] s8_prod_ff;
   logic signed [OFF_W-1:0]  s8_offc_ff;
   logic [OUT_W-1:0]         s8_temp_ff;

   assign prod_in = (PROD_W'(s7_phi_ff) <<< SPLIT) + $signed(PROD_W'(s7_plo_ff));

   always_ff @(posedge clock) begin
      if (load[7]) begin
         s8_prod_ff <= prod_in;
         s8_offc_ff <= s7_offc_ff;
         s8_temp_ff <= s7_temp_ff;
      end
   end

   // ---------------- stage 9: D1 * SENS / 2^21 - OFF ----------------
   logic signed [PROD_W-1:0] prod_b, pdiv;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  s9_acc_ff;
   logic [OUT_W-1:0]         s9_temp_ff;

   assign prod_b = s8_prod_ff + $signed(PROD_W'({P1_SH{s8_prod_ff[PROD_W-1]}}));
   assign pdiv   = prod_b >>> P1_SH;
   assign acc_in = $signed(pdiv[ACC_W-1:0]) - ACC_W'(s8_offc_ff);

   always_ff @(posedge clock) begin
      if (load[8]) begin
         s9_acc_ff  <= acc_in;
         s9_temp_ff <= s8_temp_ff;
      end
   end

   // ---------------- stage 10: result register ----------------
   logic signed [ACC_W-1:0] acc_b, pres;

   assign acc_b = s9_acc_ff + $signed(ACC_W'({P2_SH{s9_acc_ff[ACC_W-1]}}));
   assign pres  = acc_b >>> P2_SH;

   always_ff @(posedge clock) begin
      if (load[9]) begin
         rsp_temperature_centi_c <= $signed(s9_temp_ff);
         rsp_pressure_centi_mbar <= $signed(pres[OUT_W-1:0]);
      end
   end

   assign rsp_valid          = valid_ff[STAGES-1];
   assign status.stage_valid = valid_ff;

endmodule

`default_nettype wire

/* hdl/pressure_temp_compensation_top.sv */
// ----------------------------------------------------------------------------
// pressure_temp_compensation_top
// Second-order pressure/temperature compensation with calibration registers.
// ----------------------------------------------------------------------------
// Takes one raw pressure and one raw temperature conversion per transaction
// and returns temperature in 0.01 degC and pressure in 0.01 mbar. The block
// accepts one transaction every cycle while the input side is not stalled;
// each accepted transaction passes through the ten register stages of the
// compensation pipeline (the 24 x 38-bit pressure product is formed as two
// partial products in stage 7 and combined in stage 8). A stall on the result
// side holds the result and is passed back only as far as the pipeline is
// full. Write calibration words only while the block holds no transaction in
// flight; they reset to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temp_compensation_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [ptc_pkg::CIDX_W-1:0]    csr_index,
   input  wire logic [ptc_pkg::CAL_W-1:0]     csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ptc_pkg::RAW_W-1:0]     req_raw_pressure,
   input  wire logic [ptc_pkg::RAW_W-1:0]     req_raw_temperature,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [ptc_pkg::OUT_W-1:0]   rsp_temperature_centi_c,
   output logic signed [ptc_pkg::OUT_W-1:0]   rsp_pressure_centi_mbar
);
   import ptc_pkg::*;

   cal_type    cal_ff;
   cal_type    cal_in;
   status_type status;

   // Calibration register file; unknown indexes are dropped
   always_comb begin
      cal_in = cal_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SENS_BASE:         cal_in.sens_base         = csr_wdata;
            CSR_OFFSET_BASE:       cal_in.offset_base       = csr_wdata;
            CSR_SENS_TEMP_COEFF:   cal_in.sens_temp_coeff   = csr_wdata;
            CSR_OFFSET_TEMP_COEFF: cal_in.offset_temp_coeff = csr_wdata;
            CSR_REF_TEMPERATURE:   cal_in.ref_temperature   = csr_wdata;
            CSR_TEMP_SLOPE:        cal_in.temp_slope        = csr_wdata;
            default:               cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   ptc_core u_core (
      .clock                   (clock),
      .reset                   (reset),
      .cal                     (cal_ff),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_raw_pressure        (req_raw_pressure),
      .req_raw_temperature     (req_raw_temperature),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_temperature_centi_c (rsp_temperature_centi_c),
      .rsp_pressure_centi_mbar (rsp_pressure_centi_mbar),
      .status                  (status)
   );

   // ---------------- assertions ----------------
   // Without a result-side stall the pipeline always moves
   a_no_stall_passthrough: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while result side is free");

   // A full pipeline behind a stalled result must push back
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (&status.stage_valid) && rsp_stall |-> req_stall)
      else $error("full pipeline accepted a transaction");

   // An accepted transaction lands in the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> status.stage_valid[0])
      else $error("accepted transaction lost at pipeline entry");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !status.stage_valid[0])
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
